### design/gci_pkg.sv
// Shared types and constants for the grid cell interpolator.
// No dependencies; used by every module of the block except gci_fifo.
package gci_pkg;

  // Fixed port field widths.
  localparam int FRAC_FIELD_W  = 16;
  localparam int VALUE_FIELD_W = 32;
  localparam int CLOSE_W       = 17;
  localparam int MAX_VW        = 48;
  localparam int MAX_FB        = 24;

  // Configuration register indexes.
  localparam logic REG_CLOSE_DIST   = 1'b0;
  localparam logic REG_MISSING_CODE = 1'b1;

  localparam logic [CLOSE_W-1:0]       CLOSE_DIST_RST   = 17'd6554;
  localparam logic [VALUE_FIELD_W-1:0] MISSING_CODE_RST = 32'h8000_0000;

  // Modes
  localparam logic ACT_NEAREST = 1'b0;
  localparam logic ACT_LINEAR  = 1'b1;

  typedef struct packed {
    logic                             action;
    logic        [FRAC_FIELD_W-1:0]   frac_x;
    logic        [FRAC_FIELD_W-1:0]   frac_y;
    logic signed [VALUE_FIELD_W-1:0]  corner_ll;
    logic signed [VALUE_FIELD_W-1:0]  corner_hl;
    logic signed [VALUE_FIELD_W-1:0]  corner_lh;
    logic signed [VALUE_FIELD_W-1:0]  corner_hh;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_FIELD_W-1:0] result_value;
    logic                            is_missing;
  } out_item_t;

  typedef struct packed {
    logic [CLOSE_W-1:0]       close_dist;
    logic [VALUE_FIELD_W-1:0] missing_code;
  } cfg_t;

  // Width of one classified item between front and back:
  // four corners, four weights, a denominator and a missing flag.
  function automatic int mid_width(int vw, int fb);
    return 4 * vw + 5 * (2 * fb + 1) + 1;
  endfunction

endpackage

### design/grid_cell_interpolator.sv
// Top level of the grid cell interpolator: config registers, front, mid queue,
// back and result queue. Depends on gci_pkg, gci_front, gci_fifo, gci_back.
//
// Usage:
//  - Items enter through push/full: an item is taken at a clock edge with push
//    high and full low. Each item gives exactly one result, in order.
//  - Results leave through empty/pop: the oldest result sits on out_item_o
//    while empty is low and is taken at an edge with pop high.
//  - Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 close
//    distance, 1 missing sentinel). Write only while no item is in flight.
//  - Throughput: one item per cycle, sustained while results are popped.
//  - Pipeline: the back end's restoring divider resolves one quotient bit per
//    pipeline stage, most significant first.
//  - Stall: a full result queue freezes the back end; the mid queue absorbs
//    the front end until it too fills, and then full rises.
//  - Reset: all queues and pipelines empty, close distance 6554, sentinel
//    -2^31. No clearing pass is needed.
module grid_cell_interpolator #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  gci_pkg::in_item_t          in_item_i,
  output logic                       empty,
  input  logic                       pop,
  output gci_pkg::out_item_t         out_item_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [gci_pkg::VALUE_FIELD_W-1:0] cfg_data_i
);

  localparam int MW = gci_pkg::mid_width(VALUE_WIDTH, FRAC_BITS);

  logic [gci_pkg::CLOSE_W-1:0]       close_dist_q;
  logic [gci_pkg::VALUE_FIELD_W-1:0] missing_code_q;
  gci_pkg::cfg_t                     cfg;

  logic                front_ready;
  logic                mid_push, mid_full, mid_pop, mid_empty;
  logic [MW-1:0]       mid_wdata, mid_rdata;
  logic                res_push, res_full;
  gci_pkg::out_item_t  res_item;

  assign cfg.close_dist   = close_dist_q;
  assign cfg.missing_code = missing_code_q;
  assign full             = !front_ready;

  // Register file: plain writes, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      close_dist_q   <= gci_pkg::CLOSE_DIST_RST;
      missing_code_q <= gci_pkg::MISSING_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gci_pkg::REG_CLOSE_DIST: begin
          close_dist_q <= cfg_data_i[gci_pkg::CLOSE_W-1:0];
        end
        gci_pkg::REG_MISSING_CODE: begin
          missing_code_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  gci_front #(
    .VW (VALUE_WIDTH),
    .FB (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (in_item_i),
    .ready_o    (front_ready),
    .cfg_i      (cfg),
    .mid_push_o (mid_push),
    .mid_data_o (mid_wdata),
    .mid_full_i (mid_full)
  );

  // Decouples classification from the divider pipeline.
  gci_fifo #(
    .T     (logic [MW-1:0]),
    .DEPTH (4)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_rdata)
  );

  gci_back #(
    .VW (VALUE_WIDTH),
    .FB (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_rdata),
    .mid_pop_o   (mid_pop),
    .cfg_i       (cfg),
    .out_push_o  (res_push),
    .out_item_o  (res_item),
    .out_full_i  (res_full)
  );

  // Result queue: holds finished items while the consumer stalls.
  gci_fifo #(
    .T     (gci_pkg::out_item_t),
    .DEPTH (4)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_item_o)
  );

endmodule

### design/gci_fifo.sv
// Small register queue with count-based full/empty.
// Generic over item type; no package dependency.
module gci_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                mem [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/gci_front.sv
// Front end: takes items, computes distances and weights, classifies the mode.
// Uses gci_pkg; emits one flat classified item per cycle to the mid queue while it is not full.
module gci_front #(
  parameter int VW = 32,
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gci_pkg::in_item_t    item_i,
  output logic                 ready_o,
  input  gci_pkg::cfg_t        cfg_i,
  output logic                 mid_push_o,
  output logic [gci_pkg::mid_width(VW, FB)-1:0] mid_data_o,
  input  logic                 mid_full_i
);

  localparam int DW = FB + 1;
  localparam int WW = 2 * FB + 1;
  localparam int CW = (DW > gci_pkg::CLOSE_W) ? DW : gci_pkg::CLOSE_W;
  localparam logic [DW-1:0] ONE_V = DW'(1) << FB;

  typedef struct packed {
    logic                   missing;
    logic [WW-1:0]          den;
    logic [3:0][WW-1:0]     w;
    logic [3:0][VW-1:0]     c;
  } mid_t;

  typedef struct packed {
    logic                   action;
    logic [DW-1:0]          dx1, dx2, dy1, dy2;
    logic [WW-1:0]          sx1, sx2, sy1, sy2;
    logic [3:0][WW-1:0]     w;
    logic [3:0][VW-1:0]     c;
  } s1_t;

  logic   s1_v_q, s2_v_q, adv;
  s1_t    s1_d, s1_q;
  mid_t   s2_d, s2_q;

  assign adv        = !s2_v_q || !mid_full_i;
  assign ready_o    = adv;
  assign mid_push_o = s2_v_q && !mid_full_i;
  assign mid_data_o = s2_q;

  // Stage 1: distances, squares and area weights.
  always_comb begin
    logic [FB-1:0] fx, fy;
    fx = FB'(gci_pkg::MAX_FB'(item_i.frac_x));
    fy = FB'(gci_pkg::MAX_FB'(item_i.frac_y));
    s1_d.action = item_i.action;
    s1_d.dx1    = DW'(fx);
    s1_d.dx2    = ONE_V - DW'(fx);
    s1_d.dy1    = DW'(fy);
    s1_d.dy2    = ONE_V - DW'(fy);
    s1_d.sx1    = WW'(s1_d.dx1 * s1_d.dx1);
    s1_d.sx2    = WW'(s1_d.dx2 * s1_d.dx2);
    s1_d.sy1    = WW'(s1_d.dy1 * s1_d.dy1);
    s1_d.sy2    = WW'(s1_d.dy2 * s1_d.dy2);
    s1_d.w[0]   = WW'(s1_d.dx2 * s1_d.dy2);
    s1_d.w[1]   = WW'(s1_d.dx1 * s1_d.dy2);
    s1_d.w[2]   = WW'(s1_d.dx2 * s1_d.dy1);
    s1_d.w[3]   = WW'(s1_d.dx1 * s1_d.dy1);
    // corners are sign-extended then cut to VW bits
    s1_d.c[0]   = VW'(gci_pkg::MAX_VW'(item_i.corner_ll));
    s1_d.c[1]   = VW'(gci_pkg::MAX_VW'(item_i.corner_hl));
    s1_d.c[2]   = VW'(gci_pkg::MAX_VW'(item_i.corner_lh));
    s1_d.c[3]   = VW'(gci_pkg::MAX_VW'(item_i.corner_hh));
  end

  // Stage 2: pick the case and reduce it to weights over a denominator.
  always_comb begin
    logic [CW-1:0]   cd, x1, x2, y1, y2;
    logic [WW:0]     d11, d21, d12, d22;
    logic [VW-1:0]   mc_v;
    logic [3:0]      miss;
    logic [3:0]      pick;
    logic [2:0]      nmiss;
    logic [WW+1:0]   wsum;
    cd   = CW'(cfg_i.close_dist);
    x1   = CW'(s1_q.dx1);
    x2   = CW'(s1_q.dx2);
    y1   = CW'(s1_q.dy1);
    y2   = CW'(s1_q.dy2);
    d11  = (WW + 1)'(s1_q.sx1) + (WW + 1)'(s1_q.sy1);
    d21  = (WW + 1)'(s1_q.sx2) + (WW + 1)'(s1_q.sy1);
    d12  = (WW + 1)'(s1_q.sx1) + (WW + 1)'(s1_q.sy2);
    d22  = (WW + 1)'(s1_q.sx2) + (WW + 1)'(s1_q.sy2);
    mc_v = VW'(gci_pkg::MAX_VW'(signed'(cfg_i.missing_code)));
    for (int i = 0; i < 4; i++) begin
      miss[i] = (s1_q.c[i] == mc_v);
    end
    nmiss = 3'(miss[0]) + 3'(miss[1]) + 3'(miss[2]) + 3'(miss[3]);
    wsum  = '0;
    pick  = '0;
    s2_d.c       = s1_q.c;
    s2_d.w       = '0;
    s2_d.den     = WW'(1);
    s2_d.missing = 1'b0;
    if (s1_q.action == gci_pkg::ACT_NEAREST) begin
      if (d11 < d21 && d11 <= d12 && d11 <= d22) begin
        pick = 4'b0001;
      end else if (d21 < d11 && d21 <= d12 && d21 <= d22) begin
        pick = 4'b0010;
      end else if (d12 < d11 && d12 <= d21 && d12 <= d22) begin
        pick = 4'b0100;
      end else begin
        pick = 4'b1000;
      end
    end else if (x1 <= cd && y1 <= cd) begin
      pick = 4'b0001;
    end else if (x1 <= cd && y2 <= cd) begin
      pick = 4'b0100;
    end else if (x2 <= cd && y1 <= cd) begin
      pick = 4'b0010;
    end else if (x2 <= cd && y2 <= cd) begin
      pick = 4'b1000;
    end else if (s1_q.dx1 == '0) begin
      // left edge: ll and lh
      s2_d.w[0]    = WW'(s1_q.dy2);
      s2_d.w[2]    = WW'(s1_q.dy1);
      s2_d.den     = WW'(ONE_V);
      s2_d.missing = miss[0] || miss[2];
    end else if (s1_q.dy1 == '0) begin
      // bottom edge: ll and hl
      s2_d.w[0]    = WW'(s1_q.dx2);
      s2_d.w[1]    = WW'(s1_q.dx1);
      s2_d.den     = WW'(ONE_V);
      s2_d.missing = miss[0] || miss[1];
    end else begin
      for (int i = 0; i < 4; i++) begin
        s2_d.w[i] = miss[i] ? '0 : s1_q.w[i];
        wsum      = wsum + (WW + 2)'(s2_d.w[i]);
      end
      s2_d.den     = WW'(wsum);
      s2_d.missing = (nmiss > 3'd1);
    end
    // a straight pick goes through as weight one over one
    for (int i = 0; i < 4; i++) begin
      if (pick[i]) begin
        s2_d.w[i] = WW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= push_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

endmodule

### design/gci_back.sv
// Back end: weighted sum, pipelined restoring divider, rounding and result format.
// Uses gci_pkg; reads classified items from the mid queue.
module gci_back #(
  parameter int VW = 32,
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 mid_empty_i,
  input  logic [gci_pkg::mid_width(VW, FB)-1:0] mid_data_i,
  output logic                 mid_pop_o,
  input  gci_pkg::cfg_t        cfg_i,
  output logic                 out_push_o,
  output gci_pkg::out_item_t   out_item_o,
  input  logic                 out_full_i
);

  localparam int WW = 2 * FB + 1;
  localparam int PW = VW + WW + 1;
  localparam int NW = PW + 2;
  localparam int QW = VW;

  typedef struct packed {
    logic                   missing;
    logic [WW-1:0]          den;
    logic [3:0][WW-1:0]     w;
    logic [3:0][VW-1:0]     c;
  } mid_t;

  mid_t                      mid;
  logic                      adv;
  logic                      m_v_q;
  logic signed [PW-1:0]      m_p_q [4];
  logic [WW-1:0]             m_d_q;
  logic                      m_miss_q;

  logic [QW:0]               dv_v_q;
  logic [NW-1:0]             dv_r_q   [QW+1];
  logic [WW-1:0]             dv_d_q   [QW+1];
  logic [QW-1:0]             dv_q_q   [QW+1];
  logic                      dv_neg_q [QW+1];
  logic                      dv_miss_q[QW+1];

  logic [NW-1:0]             r_nx  [QW];
  logic                      qb_nx [QW];
  logic signed [NW-1:0]      n_sum;
  logic [NW-1:0]             n_mag;

  assign mid        = mid_data_i;
  assign adv        = !dv_v_q[QW] || !out_full_i;
  assign mid_pop_o  = adv && !mid_empty_i;
  assign out_push_o = dv_v_q[QW] && !out_full_i;

  assign n_sum = NW'(m_p_q[0]) + NW'(m_p_q[1]) + NW'(m_p_q[2]) + NW'(m_p_q[3]);
  assign n_mag = n_sum[NW-1] ? NW'(-n_sum) : NW'(n_sum);

  // one quotient bit per stage, most significant first
  always_comb begin
    logic [NW-1:0] dsh;
    for (int j = 0; j < QW; j++) begin
      dsh      = NW'(dv_d_q[j]) << (QW - 1 - j);
      qb_nx[j] = (dv_r_q[j] >= dsh);
      r_nx[j]  = qb_nx[j] ? dv_r_q[j] - dsh : dv_r_q[j];
    end
  end

  // round half away from zero, restore sign, format
  always_comb begin
    logic [WW:0]           r2;
    logic [QW:0]           qr;
    logic [VW-1:0]         res;
    logic [VW-1:0]         mc_v;
    logic signed [gci_pkg::MAX_VW-1:0] ext;
    r2   = {dv_r_q[QW][WW-1:0], 1'b0};
    qr   = (QW + 1)'(dv_q_q[QW]) + (QW + 1)'(r2 >= (WW + 1)'(dv_d_q[QW]));
    res  = dv_neg_q[QW] ? VW'(-qr) : VW'(qr);
    ext  = gci_pkg::MAX_VW'(signed'(res));
    mc_v = VW'(gci_pkg::MAX_VW'(signed'(cfg_i.missing_code)));
    if (dv_miss_q[QW]) begin
      out_item_o.result_value = cfg_i.missing_code;
      out_item_o.is_missing   = 1'b1;
    end else begin
      out_item_o.result_value = ext[gci_pkg::VALUE_FIELD_W-1:0];
      out_item_o.is_missing   = (res == mc_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q  <= 1'b0;
      dv_v_q <= '0;
    end else if (adv) begin
      m_v_q  <= !mid_empty_i;
      dv_v_q <= {dv_v_q[QW-1:0], m_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        m_p_q[i] <= PW'(signed'(mid.c[i]) * signed'({1'b0, mid.w[i]}));
      end
      m_d_q    <= mid.den;
      m_miss_q <= mid.missing;

      dv_r_q[0]    <= n_mag;
      dv_d_q[0]    <= m_d_q;
      dv_q_q[0]    <= '0;
      dv_neg_q[0]  <= n_sum[NW-1];
      dv_miss_q[0] <= m_miss_q;
      for (int j = 0; j < QW; j++) begin
        dv_r_q[j+1]    <= r_nx[j];
        dv_d_q[j+1]    <= dv_d_q[j];
        dv_q_q[j+1]    <= dv_q_q[j] | (QW'(qb_nx[j]) << (QW - 1 - j));
        dv_neg_q[j+1]  <= dv_neg_q[j];
        dv_miss_q[j+1] <= dv_miss_q[j];
      end
    end
  end

endmodule

### design/gci_checker.sv
// Port-level checks for grid_cell_interpolator, attached by bind.
// Depends on gci_pkg for the item types.
module gci_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input gci_pkg::out_item_t         out_item_o,
  input logic                       cfg_we_i,
  input logic                       cfg_idx_i,
  input logic [gci_pkg::VALUE_FIELD_W-1:0] cfg_data_i
);

  logic [gci_pkg::VALUE_FIELD_W-1:0] mc_q;
  logic [7:0]                        pend_q;
  logic                              in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q   <= gci_pkg::MISSING_CODE_RST;
      pend_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == gci_pkg::REG_MISSING_CODE) begin
        mc_q <= cfg_data_i;
      end
      pend_q <= pend_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pend_q != '0)
    else $error("result shown with no item outstanding");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("waiting result changed");

  a_sentinel_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.result_value == mc_q |-> out_item_o.is_missing)
    else $error("sentinel value without missing flag");

endmodule

bind grid_cell_interpolator gci_checker u_gci_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o),
  .cfg_we_i   (cfg_we_i),
  .cfg_idx_i  (cfg_idx_i),
  .cfg_data_i (cfg_data_i)
);
